// ----- rtl/c3x3_pkg.sv -----
// Shared types, constants and helpers for the 3x3 convolution block.
`timescale 1ns / 1ps
`default_nettype none

package c3x3_pkg;

    // Geometry and field widths
    localparam int C_MAX_W     = 1024;
    localparam int C_ADDR_W    = $clog2(C_MAX_W);
    localparam int C_PIX_W     = 8;
    localparam int C_WGT_W     = 8;
    localparam int C_KREG_W    = 3 * C_WGT_W;
    localparam int C_IW_W      = 11;
    localparam int C_IH_W      = 16;
    localparam int C_COL_W     = 10;
    localparam int C_ROW_W     = 16;
    localparam int C_SUM_W     = 16;
    localparam int C_PROD_W    = C_PIX_W + C_WGT_W + 1;
    localparam int C_CFG_IDX_W = 3;

    // Output queue
    localparam int C_OQ_DEPTH  = 8;
    localparam int C_OQ_PTR_W  = $clog2(C_OQ_DEPTH);
    localparam int C_OQ_CNT_W  = $clog2(C_OQ_DEPTH) + 1;

    // Running statistics start values
    localparam logic signed [C_SUM_W-1:0] C_MIN_INIT = {1'b0, {(C_SUM_W-1){1'b1}}};
    localparam logic signed [C_SUM_W-1:0] C_MAX_INIT = {1'b1, {(C_SUM_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_K_BELOW  = 3'd0,
        CFG_K_CENTER = 3'd1,
        CFG_K_ABOVE  = 3'd2,
        CFG_IMG_W    = 3'd3,
        CFG_IMG_H    = 3'd4
    } t_cfg_idx;

    // One line-store entry: the two rows above the incoming pixel
    typedef struct packed {
        logic [C_PIX_W-1:0] upper;
        logic [C_PIX_W-1:0] lower;
    } t_line;

    // One window column, oldest row first
    typedef struct packed {
        logic [C_PIX_W-1:0] upper;
        logic [C_PIX_W-1:0] lower;
        logic [C_PIX_W-1:0] newest;
    } t_col;

    // Weights for one window column
    typedef struct packed {
        logic signed [C_WGT_W-1:0] above;
        logic signed [C_WGT_W-1:0] center;
        logic signed [C_WGT_W-1:0] below;
    } t_wcol;

    // One result word
    typedef struct packed {
        logic signed [C_SUM_W-1:0] filtered;
        logic [C_COL_W-1:0]        column;
        logic [C_ROW_W-1:0]        row;
        logic                      frame_done;
        logic signed [C_SUM_W-1:0] lowest;
        logic signed [C_SUM_W-1:0] highest;
    } t_res;

    // Pick the weights of tap i_tap (0 = right of center) from the three kernel rows
    function automatic t_wcol f_wcol(input logic [C_KREG_W-1:0] i_below,
                                     input logic [C_KREG_W-1:0] i_center,
                                     input logic [C_KREG_W-1:0] i_above,
                                     input int unsigned         i_tap);
        t_wcol v;
        v.below  = i_below[i_tap*C_WGT_W +: C_WGT_W];
        v.center = i_center[i_tap*C_WGT_W +: C_WGT_W];
        v.above  = i_above[i_tap*C_WGT_W +: C_WGT_W];
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/c3x3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module c3x3_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/c3x3_cell.sv -----
// One window cell: holds a pixel column, passes it on, adds its weighted column to the sum.
`timescale 1ns / 1ps
`default_nettype none

module c3x3_cell import c3x3_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_shift,
    input  wire t_col               i_col,
    input  wire t_wcol              i_wgt,
    input  wire logic [C_SUM_W-1:0] i_psum,
    output t_col                    o_col,
    output logic      [C_SUM_W-1:0] o_psum
);

    t_col r_col;
    logic signed [C_PROD_W-1:0] w_prod_up;
    logic signed [C_PROD_W-1:0] w_prod_lo;
    logic signed [C_PROD_W-1:0] w_prod_nw;

    // Take the neighbor's column when a word moves down the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // Weight the three rows; the sum wraps at the result width
    assign w_prod_up = $signed({1'b0, r_col.upper})  * i_wgt.above;
    assign w_prod_lo = $signed({1'b0, r_col.lower})  * i_wgt.center;
    assign w_prod_nw = $signed({1'b0, r_col.newest}) * i_wgt.below;

    assign o_psum = i_psum + w_prod_up[C_SUM_W-1:0] + w_prod_lo[C_SUM_W-1:0]
                  + w_prod_nw[C_SUM_W-1:0];
    assign o_col  = r_col;

endmodule

`default_nettype wire

// ----- rtl/c3x3_outq.sv -----
// Small result queue that decouples the pipeline from the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module c3x3_outq import c3x3_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_res                  i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_res                       o_data,
    output logic      [C_OQ_CNT_W-1:0] o_cnt
);

    t_res                  r_mem [0:C_OQ_DEPTH-1];
    logic [C_OQ_PTR_W-1:0] r_wp;
    logic [C_OQ_PTR_W-1:0] r_rp;
    logic [C_OQ_CNT_W-1:0] r_cnt;
    logic [C_OQ_PTR_W-1:0] n_wp;
    logic [C_OQ_PTR_W-1:0] n_rp;
    logic [C_OQ_CNT_W-1:0] n_cnt;
    logic                  w_pop;

    assign w_pop = o_valid && i_ready;

    // Advance pointers and occupancy
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == C_OQ_PTR_W'(C_OQ_DEPTH - 1)) ? '0 : r_wp + C_OQ_PTR_W'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == C_OQ_PTR_W'(C_OQ_DEPTH - 1)) ? '0 : r_rp + C_OQ_PTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + C_OQ_CNT_W'(1);
        end else if (w_pop && !i_push) begin
            n_cnt = r_cnt - C_OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_cnt   = r_cnt;

    // The credit check upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < C_OQ_CNT_W'(C_OQ_DEPTH)))
        else $error("result pushed into a full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= C_OQ_CNT_W'(C_OQ_DEPTH))
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// ----- rtl/conv3x3_byte_image.sv -----
// Top level of the 3x3 convolution over a raster stream of byte pixels.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit pixel per clock in raster order and returns, for every interior pixel, the
// 3x3 kernel sum wrapped to 16 bits with its position, a last-of-frame flag and the running
// minimum and maximum of the frame. Sustained rate is one pixel per clock while results are
// taken; a result passes stage 1, the window cells, the registered sum and the output queue.
// Two rows of history sit in one 1024 x 16 RAM, read when the pixel is taken and written back
// the next cycle. The window is a chain of three column cells that shift once per word and
// each add their weighted column into the sum. An 8-word output queue lets input continue
// while results wait; input is held off when that queue and the pipeline could overflow. After
// reset the line RAM is cleared one entry per clock, and input is not accepted until all 1024
// entries are clear; configuration writes are taken at any time. Kernel and size registers
// are to be written only while the block holds no pixel in flight.
module conv3x3_byte_image import c3x3_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [C_KREG_W-1:0]     i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [C_PIX_W-1:0]      i_pixel,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [C_SUM_W-1:0]    o_filtered,
    output logic        [C_COL_W-1:0]    o_column,
    output logic        [C_ROW_W-1:0]    o_row,
    output logic                         o_frame_done,
    output logic signed [C_SUM_W-1:0]    o_lowest_so_far,
    output logic signed [C_SUM_W-1:0]    o_highest_so_far
);

    // Configuration
    logic [C_KREG_W-1:0] r_k_below;
    logic [C_KREG_W-1:0] r_k_center;
    logic [C_KREG_W-1:0] r_k_above;
    logic [C_IW_W-1:0]   r_img_w;
    logic [C_IH_W-1:0]   r_img_h;
    logic [C_IW_W-1:0]   w_eff_w;
    logic [C_IH_W-1:0]   w_eff_h;

    // Position counters
    logic [C_ADDR_W-1:0] r_col;
    logic [C_ROW_W-1:0]  r_row;
    logic [C_ADDR_W-1:0] n_col;
    logic [C_ROW_W-1:0]  n_row;
    logic                w_wrap_c;
    logic [C_ROW_W:0]    w_row_a;
    logic [C_ADDR_W-1:0] w_x;
    logic [C_ROW_W-1:0]  w_y;
    logic [C_IW_W-1:0]   w_x_nxt;
    logic [C_ROW_W:0]    w_y_nxt;
    logic                w_res;
    logic                w_last;
    logic                w_acc;

    // Line RAM clearing
    logic                r_init_done;
    logic [C_ADDR_W-1:0] r_clr_addr;

    // Line RAM ports
    logic                w_ram_we;
    logic [C_ADDR_W-1:0] w_ram_waddr;
    t_line               w_ram_wdata;
    t_line               w_ram_rdata;

    // Stage 1: pixel taken, line RAM read under way
    logic                r_s1_vld;
    logic                r_s1_res;
    logic                r_s1_clr;
    logic                r_s1_last;
    logic [C_PIX_W-1:0]  r_s1_pix;
    logic [C_ADDR_W-1:0] r_s1_x;
    logic [C_COL_W-1:0]  r_s1_ocol;
    logic [C_ROW_W-1:0]  r_s1_orow;

    // Stage 2: window cells hold the neighborhood
    logic                r_s2_vld;
    logic                r_s2_res;
    logic                r_s2_clr;
    logic                r_s2_last;
    logic [C_COL_W-1:0]  r_s2_ocol;
    logic [C_ROW_W-1:0]  r_s2_orow;

    // Stage 3: registered sum
    logic                r_s3_vld;
    logic                r_s3_res;
    logic                r_s3_clr;
    logic                r_s3_last;
    logic [C_COL_W-1:0]  r_s3_ocol;
    logic [C_ROW_W-1:0]  r_s3_orow;
    logic [C_SUM_W-1:0]  r_s3_sum;

    // Cell chain
    t_col                w_cc [0:2];
    logic [C_SUM_W-1:0]  w_ps [0:3];

    // Running statistics and output queue
    logic signed [C_SUM_W-1:0] r_min;
    logic signed [C_SUM_W-1:0] r_max;
    logic signed [C_SUM_W-1:0] w_lo_n;
    logic signed [C_SUM_W-1:0] w_hi_n;
    logic                      w_push;
    t_res                      w_push_data;
    t_res                      w_out;
    logic [C_OQ_CNT_W-1:0]     w_oq_cnt;
    logic [1:0]                w_inflight;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_below  <= '0;
            r_k_center <= '0;
            r_k_above  <= '0;
            r_img_w    <= C_IW_W'(1024);
            r_img_h    <= C_IH_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_K_BELOW:  r_k_below  <= i_cfg_data;
                CFG_K_CENTER: r_k_center <= i_cfg_data;
                CFG_K_ABOVE:  r_k_above  <= i_cfg_data;
                CFG_IMG_W:    r_img_w    <= i_cfg_data[C_IW_W-1:0];
                CFG_IMG_H:    r_img_h    <= i_cfg_data[C_IH_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the frame to at least 3 x 3 and the width to what the line RAM supports
    always_comb begin
        if (r_img_w < C_IW_W'(3)) begin
            w_eff_w = C_IW_W'(3);
        end else if (r_img_w > C_IW_W'(C_MAX_W)) begin
            w_eff_w = C_IW_W'(C_MAX_W);
        end else begin
            w_eff_w = r_img_w;
        end
        w_eff_h = (r_img_h < C_IH_W'(3)) ? C_IH_W'(3) : r_img_h;
    end

    // Position of the incoming pixel; counters wrap again if the size shrank
    always_comb begin
        w_wrap_c = {1'b0, r_col} >= w_eff_w;
        w_row_a  = w_wrap_c ? {1'b0, r_row} + (C_ROW_W+1)'(1) : {1'b0, r_row};
        w_y      = (w_row_a >= {1'b0, w_eff_h}) ? '0 : w_row_a[C_ROW_W-1:0];
        w_x      = w_wrap_c ? '0 : r_col;
        w_x_nxt  = {1'b0, w_x} + C_IW_W'(1);
        w_y_nxt  = {1'b0, w_y} + (C_ROW_W+1)'(1);
        if (w_x_nxt >= w_eff_w) begin
            n_col = '0;
            n_row = (w_y_nxt >= {1'b0, w_eff_h}) ? '0 : w_y_nxt[C_ROW_W-1:0];
        end else begin
            n_col = w_x_nxt[C_ADDR_W-1:0];
            n_row = w_y;
        end
        w_res  = (w_x >= C_ADDR_W'(2)) && (w_y >= C_ROW_W'(2));
        w_last = (w_x_nxt == w_eff_w) && (w_y == w_eff_h - C_IH_W'(1));
    end

    // Hold off input during clearing and while the queue could overflow
    assign w_inflight = {1'b0, r_s1_vld} + {1'b0, r_s2_vld} + {1'b0, r_s3_vld};
    assign o_ready    = r_init_done &&
                        ((w_oq_cnt + {{(C_OQ_CNT_W-2){1'b0}}, w_inflight})
                         < C_OQ_CNT_W'(C_OQ_DEPTH));
    assign w_acc      = i_valid && o_ready;

    // Counters and line RAM clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_init_done <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            if (!r_init_done) begin
                r_clr_addr <= r_clr_addr + C_ADDR_W'(1);
                if (r_clr_addr == C_ADDR_W'(C_MAX_W - 1)) begin
                    r_init_done <= 1'b1;
                end
            end
            if (w_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Line RAM: read at take, write back the shifted rows from stage 1, zeros while clearing
    assign w_ram_we    = !r_init_done || r_s1_vld;
    assign w_ram_waddr = r_init_done ? r_s1_x : r_clr_addr;
    always_comb begin
        w_ram_wdata = '0;
        if (r_init_done) begin
            w_ram_wdata.upper = w_ram_rdata.lower;
            w_ram_wdata.lower = r_s1_pix;
        end
    end

    c3x3_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (C_MAX_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_acc),
        .i_raddr (w_x),
        .o_rdata (w_ram_rdata)
    );

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_res  <= w_res;
            r_s1_clr  <= (w_y == '0);
            r_s1_last <= w_last;
            r_s1_pix  <= i_pixel;
            r_s1_x    <= w_x;
            r_s1_ocol <= C_COL_W'(w_x - C_ADDR_W'(1));
            r_s1_orow <= w_y - C_ROW_W'(1);
        end
        if (r_s1_vld) begin
            r_s2_res  <= r_s1_res;
            r_s2_clr  <= r_s1_clr;
            r_s2_last <= r_s1_last;
            r_s2_ocol <= r_s1_ocol;
            r_s2_orow <= r_s1_orow;
        end
        if (r_s2_vld) begin
            r_s3_res  <= r_s2_res;
            r_s3_clr  <= r_s2_clr;
            r_s3_last <= r_s2_last;
            r_s3_ocol <= r_s2_ocol;
            r_s3_orow <= r_s2_orow;
            r_s3_sum  <= w_ps[0];
        end
    end

    // Window column entering the chain: two stored rows and the new pixel
    assign w_cc[0] = {w_ram_rdata.upper, w_ram_rdata.lower, r_s1_pix};
    assign w_ps[3] = '0;

    // Chain of cells: cell 0 holds the newest column, the sum flows toward it
    for (genvar g = 0; g < 3; g++) begin : g_cell
        if (g < 2) begin : g_mid
            c3x3_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (r_s1_vld),
                .i_col   (w_cc[g]),
                .i_wgt   (f_wcol(r_k_below, r_k_center, r_k_above, g)),
                .i_psum  (w_ps[g+1]),
                .o_col   (w_cc[g+1]),
                .o_psum  (w_ps[g])
            );
        end else begin : g_end
            c3x3_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (r_s1_vld),
                .i_col   (w_cc[g]),
                .i_wgt   (f_wcol(r_k_below, r_k_center, r_k_above, g)),
                .i_psum  (w_ps[g+1]),
                .o_col   (),
                .o_psum  (w_ps[g])
            );
        end
    end

    // Running minimum and maximum; restart on the first row of each frame
    assign w_lo_n = ($signed(r_s3_sum) < r_min) ? $signed(r_s3_sum) : r_min;
    assign w_hi_n = ($signed(r_s3_sum) > r_max) ? $signed(r_s3_sum) : r_max;
    assign w_push = r_s3_vld && r_s3_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= C_MIN_INIT;
            r_max <= C_MAX_INIT;
        end else if (r_s3_vld && r_s3_clr) begin
            r_min <= C_MIN_INIT;
            r_max <= C_MAX_INIT;
        end else if (w_push) begin
            r_min <= w_lo_n;
            r_max <= w_hi_n;
        end
    end

    always_comb begin
        w_push_data.filtered   = $signed(r_s3_sum);
        w_push_data.column     = r_s3_ocol;
        w_push_data.row        = r_s3_orow;
        w_push_data.frame_done = r_s3_last;
        w_push_data.lowest     = w_lo_n;
        w_push_data.highest    = w_hi_n;
    end

    c3x3_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out),
        .o_cnt   (w_oq_cnt)
    );

    assign o_filtered       = w_out.filtered;
    assign o_column         = w_out.column;
    assign o_row            = w_out.row;
    assign o_frame_done     = w_out.frame_done;
    assign o_lowest_so_far  = w_out.lowest;
    assign o_highest_so_far = w_out.highest;

    // No word may be in the pipeline while the line RAM is still being cleared
    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init_done |-> !(r_s1_vld || r_s2_vld || r_s3_vld))
        else $error("pixel in flight during line RAM clearing");

    // A pushed result leaves the frame range ordered
    a_stats_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_min <= r_max))
        else $error("frame minimum above frame maximum after a result");

    // A statistics restart never coincides with a result
    a_clr_not_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> !(r_s3_res && r_s3_clr))
        else $error("result flagged on a frame restart word");

endmodule

`default_nettype wire

// ----- tb/conv3x3_byte_image_tb.sv -----
// Self-checking testbench for the 3x3 convolution block over a byte pixel stream.
`timescale 1ns / 1ps

module conv3x3_byte_image_tb;
    import c3x3_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RAND_WORDS = 600;
    localparam int WIDE_WORDS = 60;
    localparam int SETTLE     = 8;
    localparam int TAIL       = 20;
    localparam int HOLD_LONG  = 400;
    localparam int SHOW_MAX   = 10;
    localparam int LIMIT      = 1_000_000;
    localparam int PLAN_LEN   = 33;

    localparam logic [C_KREG_W-1:0] K_ZERO     = 24'h000000;
    localparam logic [C_KREG_W-1:0] K_MOST_NEG = 24'h808080;
    localparam logic [C_KREG_W-1:0] K_MOST_POS = 24'h7F7F7F;
    localparam logic [C_KREG_W-1:0] K_ALL_ONES = 24'hFFFFFF;

    typedef enum logic {ROW_REG, ROW_PIX} t_row_kind;

    // One row of the directed plan: a register write or a pixel word
    typedef struct packed {
        t_row_kind                 kind;
        t_cfg_idx                  idx;
        logic [C_KREG_W-1:0]       data;
        logic [C_PIX_W-1:0]        pix;
        logic                      typed;
        logic signed [C_SUM_W-1:0] sum;
    } t_step;

    // Clock, reset and block ports
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    t_cfg_idx                   cfg_idx = CFG_K_BELOW;
    logic [C_KREG_W-1:0]        cfg_data = '0;
    logic                       pix_valid = 1'b0;
    logic                       pix_ready;
    logic [C_PIX_W-1:0]         pixel = '0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic signed [C_SUM_W-1:0]  res_filtered;
    logic        [C_COL_W-1:0]  res_column;
    logic        [C_ROW_W-1:0]  res_row;
    logic                       res_frame_done;
    logic signed [C_SUM_W-1:0]  res_lowest;
    logic signed [C_SUM_W-1:0]  res_highest;

    // Predictor state and its copy of the registers
    logic [C_PIX_W-1:0]  line_upper [C_MAX_W] = '{default: '0};
    logic [C_PIX_W-1:0]  line_lower [C_MAX_W] = '{default: '0};
    logic [C_PIX_W-1:0]  win [3][3] = '{default: '{default: '0}};
    int                  col_cnt = 0;
    int                  row_cnt = 0;
    int                  run_min = 32767;
    int                  run_max = -32768;
    logic [C_KREG_W-1:0] k_below = '0;
    logic [C_KREG_W-1:0] k_center = '0;
    logic [C_KREG_W-1:0] k_above = '0;
    logic [C_IW_W-1:0]   img_w = 11'd1024;
    logic [C_IH_W-1:0]   img_h = 16'd1024;

    t_res        awaited_words [$];
    int          n_fail = 0;
    int unsigned cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          hold_req = 1'b0;

    // Directed plan: small frames at the kernel extremes, then a width shrink mid-row
    t_step plan [PLAN_LEN] = '{
        '{ROW_REG, CFG_IMG_W,    24'd2,      8'h00, 1'b0, 16'sd0},
        '{ROW_REG, CFG_IMG_H,    24'd65535,  8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        // kernel still at reset: the first sum is zero
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h00, 1'b1, 16'sd0},
        '{ROW_REG, CFG_K_BELOW,  K_MOST_NEG, 8'h00, 1'b0, 16'sd0},
        '{ROW_REG, CFG_K_CENTER, K_MOST_NEG, 8'h00, 1'b0, 16'sd0},
        '{ROW_REG, CFG_K_ABOVE,  K_MOST_NEG, 8'h00, 1'b0, 16'sd0},
        // height below the minimum, row count already past it: new frame
        '{ROW_REG, CFG_IMG_H,    24'd0,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b0, 16'sd0},
        // nine times 255 * -128, wrapped to 16 bits
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFF, 1'b1, -16'sd31616},
        '{ROW_REG, CFG_IMG_W,    24'd8,      8'h00, 1'b0, 16'sd0},
        '{ROW_REG, CFG_K_CENTER, K_MOST_POS, 8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h01, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h80, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h7F, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hFE, 1'b0, 16'sd0},
        // shrink the width under the column count: wrap to the next row
        '{ROW_REG, CFG_IMG_W,    24'd3,      8'h00, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'hAA, 1'b0, 16'sd0},
        '{ROW_PIX, CFG_K_BELOW,  24'd0,      8'h55, 1'b0, 16'sd0}
    };

    conv3x3_byte_image u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_valid          (pix_valid),
        .o_ready          (pix_ready),
        .i_pixel          (pixel),
        .o_valid          (res_valid),
        .i_ready          (res_ready),
        .o_filtered       (res_filtered),
        .o_column         (res_column),
        .o_row            (res_row),
        .o_frame_done     (res_frame_done),
        .o_lowest_so_far  (res_lowest),
        .o_highest_so_far (res_highest)
    );

    always #(CLK_HALF) clk = ~clk;

    // Bound the run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [C_PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 99) < 20)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return C_PIX_W'($urandom());
    endfunction

    function automatic logic [C_KREG_W-1:0] pick_kernel();
        case ($urandom_range(0, 7))
            0: return K_ZERO;
            1: return K_MOST_NEG;
            2: return K_MOST_POS;
            3: return K_ALL_ONES;
            default: return C_KREG_W'($urandom());
        endcase
    endfunction

    function automatic logic [C_KREG_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return C_KREG_W'($urandom_range(0, 2));
        if (r < 80) return C_KREG_W'($urandom_range(3, 12));
        if (r < 95) return C_KREG_W'($urandom_range(13, 40));
        return C_KREG_W'($urandom_range(1024, 2047));
    endfunction

    function automatic logic [C_KREG_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return C_KREG_W'($urandom_range(0, 2));
        if (r < 85) return C_KREG_W'($urandom_range(3, 10));
        if (r < 95) return C_KREG_W'($urandom_range(11, 40));
        return 24'd65535;
    endfunction

    function automatic int weight(input logic [C_KREG_W-1:0] k, input int tap);
        return int'($signed(k[tap*C_WGT_W +: C_WGT_W]));
    endfunction

    // Advance the window by one pixel and work out the result word it yields, if any
    task automatic filter_pixel(input logic [C_PIX_W-1:0] p, output bit has, output t_res w);
        int wid, hgt, x, y, acc, v;
        bit last;
        wid = int'(img_w);
        hgt = int'(img_h);
        if (wid < 3) wid = 3;
        if (wid > C_MAX_W) wid = C_MAX_W;
        if (hgt < 3) hgt = 3;

        // wrap counters left beyond a shrunk size
        if (col_cnt >= wid) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= hgt) begin
            row_cnt = 0;
            run_min = 32767;
            run_max = -32768;
        end
        x = col_cnt;
        y = row_cnt;
        if (x >= C_MAX_W) x = C_MAX_W - 1;

        // shift the window, pull the column from the line stores
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = line_upper[x];
        win[1][2] = line_lower[x];
        win[2][2] = p;
        line_upper[x] = line_lower[x];
        line_lower[x] = p;

        last = (x == wid - 1) && (y == hgt - 1);
        has = 1'b0;
        w = '0;
        if (x >= 2 && y >= 2) begin
            // weight field k pairs with window column 2-k: flipped kernel
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                acc += int'(win[2][2-c]) * weight(k_below, c);
                acc += int'(win[1][2-c]) * weight(k_center, c);
                acc += int'(win[0][2-c]) * weight(k_above, c);
            end
            v = int'($signed(acc[C_SUM_W-1:0]));
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
            w.filtered   = acc[C_SUM_W-1:0];
            w.column     = C_COL_W'(x - 1);
            w.row        = C_ROW_W'(y - 1);
            w.frame_done = last;
            w.lowest     = run_min[C_SUM_W-1:0];
            w.highest    = run_max[C_SUM_W-1:0];
            has = 1'b1;
        end

        // step the counters, close the frame after its last pixel
        col_cnt++;
        if (col_cnt >= wid) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= hgt) begin
                row_cnt = 0;
                run_min = 32767;
                run_max = -32768;
            end
        end
    endtask

    task automatic flag_error(input string msg);
        n_fail++;
        if (n_fail <= SHOW_MAX)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Compare one taken result word with the oldest awaited one
    task automatic check_word();
        t_res e;
        if (awaited_words.size() == 0) begin
            flag_error($sformatf("unexpected word, column %0d row %0d filtered %0d",
                                 res_column, res_row, res_filtered));
            return;
        end
        e = awaited_words.pop_front();
        if (res_filtered !== e.filtered)
            flag_error($sformatf("filtered: expected %0d, got %0d", e.filtered, res_filtered));
        if (res_column !== e.column)
            flag_error($sformatf("column: expected %0d, got %0d", e.column, res_column));
        if (res_row !== e.row)
            flag_error($sformatf("row: expected %0d, got %0d", e.row, res_row));
        if (res_frame_done !== e.frame_done)
            flag_error($sformatf("frame_done: expected %0b, got %0b",
                                 e.frame_done, res_frame_done));
        if (res_lowest !== e.lowest)
            flag_error($sformatf("lowest: expected %0d, got %0d", e.lowest, res_lowest));
        if (res_highest !== e.highest)
            flag_error($sformatf("highest: expected %0d, got %0d", e.highest, res_highest));
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) check_word();
    end

    // Receiver: random stalls, quiet stretches, and a long hold-off on request
    initial begin : rx_drive
        int gap;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_LONG - 1) @(negedge clk);
            end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                res_ready <= 1'b0;
                gap = pick_gap();
                repeat (gap - 1) @(negedge clk);
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Drop valid for a number of cycles
    task automatic idle(input int n);
        repeat (n) begin
            @(negedge clk);
            pix_valid <= 1'b0;
        end
    endtask

    task automatic tx_pause();
        if (!tx_calm && $urandom_range(0, 99) < 30) idle(pick_gap());
    endtask

    // Offer one pixel word, hold it until taken, then record what it should yield
    task automatic drive_word(input logic [C_PIX_W-1:0] p, input logic typed,
                              input logic signed [C_SUM_W-1:0] sum);
        bit has;
        t_res w;
        @(negedge clk);
        pix_valid <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (!pix_ready);
        filter_pixel(p, has, w);
        if (has) begin
            if (typed) w.filtered = sum;
            awaited_words.push_back(w);
        end
    endtask

    // Wait for every awaited word, then let border pixels leave the pipeline
    task automatic settle();
        idle(1);
        while (awaited_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [C_KREG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_K_BELOW:  k_below = val;
            CFG_K_CENTER: k_center = val;
            CFG_K_ABOVE:  k_above = val;
            CFG_IMG_W:    img_w = val[C_IW_W-1:0];
            CFG_IMG_H:    img_h = val[C_IH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : main_flow
        int n_words, n, phase;
        n_words = 0;
        phase = 0;

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed plan
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_REG) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                tx_pause();
                drive_word(plan[i].pix, plan[i].typed, plan[i].sum);
            end
        end

        // random phases, each with its own register setting
        while (n_words < RAND_WORDS) begin
            settle();
            if ($urandom_range(0, 1)) write_reg(CFG_K_BELOW, pick_kernel());
            if ($urandom_range(0, 1)) write_reg(CFG_K_CENTER, pick_kernel());
            if ($urandom_range(0, 1)) write_reg(CFG_K_ABOVE, pick_kernel());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_IMG_W, pick_width());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_IMG_H, pick_height());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(8, 60);

            // fill the block while the receiver holds off
            if (phase == 2) begin
                write_reg(CFG_IMG_W, 24'd4);
                tx_calm = 1'b1;
                hold_req = 1'b1;
                n = 80;
            end
            // width field beyond the line store
            if (phase == 4) begin
                write_reg(CFG_IMG_W, 24'd2047);
                write_reg(CFG_IMG_H, C_KREG_W'($urandom_range(0, 3)));
                n = WIDE_WORDS;
            end

            repeat (n) begin
                tx_pause();
                drive_word(pick_pixel(), 1'b0, '0);
            end
            n_words += n;
            phase++;
        end

        settle();
        repeat (TAIL) @(posedge clk);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/c3x3_pkg.sv
rtl/c3x3_ram.sv
rtl/c3x3_cell.sv
rtl/c3x3_outq.sv
rtl/conv3x3_byte_image.sv
tb/conv3x3_byte_image_tb.sv
